>>> rtl/core/fepc_pkg.sv
// Package for the frame-extended PWM compare core.
// Holds the shared codes, widths and types. It depends on nothing else.
package fepc_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned DUTY_W     = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 8;

  // Operation codes of an input item.
  localparam logic OP_SET  = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_MAX_CYCLE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_POSITION = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_CYCLE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_POSITION = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_LENGTH = 3'd4;

  // Reset values of the configuration registers.
  localparam logic [BYTE_W-1:0] MAX_CYCLE_RST    = 8'hFF;
  localparam logic [BYTE_W-1:0] MAX_POSITION_RST = 8'hFF;
  localparam logic [BYTE_W-1:0] MIN_CYCLE_RST    = 8'h00;
  localparam logic [BYTE_W-1:0] MIN_POSITION_RST = 8'h00;
  localparam logic [BYTE_W-1:0] FRAME_LENGTH_RST = 8'd117;

  // Compare levels before and after the active period of a frame.
  localparam logic [BYTE_W-1:0] CMP_FULL  = 8'hFF;
  localparam logic [BYTE_W-1:0] CMP_EMPTY = 8'h00;

  typedef struct packed {
    logic [BYTE_W-1:0] max_cycle;
    logic [BYTE_W-1:0] max_position;
    logic [BYTE_W-1:0] min_cycle;
    logic [BYTE_W-1:0] min_position;
  } fepc_limits_t;

endpackage

>>> rtl/core/fepc_if.sv
// Handshake interfaces of the frame-extended PWM compare core.
// Depends on fepc_pkg for the field widths.
interface fepc_cmd_if;
  logic                          valid;
  logic                          ready;
  logic                          operation;
  logic                          channel;
  logic [fepc_pkg::DUTY_W-1:0]   duty_value;

  modport source (output valid, operation, channel, duty_value, input ready);
  modport sink   (input valid, operation, channel, duty_value, output ready);
endinterface

interface fepc_result_if;
  logic                          valid;
  logic                          ready;
  logic [fepc_pkg::BYTE_W-1:0]   frame_index;
  logic [fepc_pkg::BYTE_W-1:0]   compare_a;
  logic [fepc_pkg::BYTE_W-1:0]   compare_b;

  modport source (output valid, frame_index, compare_a, compare_b, input ready);
  modport sink   (input valid, frame_index, compare_a, compare_b, output ready);
endinterface

interface fepc_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [fepc_pkg::CFG_IDX_W-1:0]  index;
  logic [fepc_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/core/fepc_clamp.sv
// Clamp of a 16-bit duty value into a cycle index and a position.
// Depends on fepc_pkg for the limits type.
module fepc_clamp (
  input  logic [fepc_pkg::DUTY_W-1:0] duty_value,
  input  fepc_pkg::fepc_limits_t      limits,
  output logic [fepc_pkg::BYTE_W-1:0] cycle,
  output logic [fepc_pkg::BYTE_W-1:0] position
);

  logic [fepc_pkg::BYTE_W-1:0] cyc_hi;
  logic [fepc_pkg::BYTE_W-1:0] pos_hi;

  // The upper clamp is applied first, then the lower one on its result.
  always_comb begin
    cyc_hi = duty_value[fepc_pkg::DUTY_W-1:fepc_pkg::BYTE_W];
    pos_hi = duty_value[fepc_pkg::BYTE_W-1:0];
    if (cyc_hi > limits.max_cycle) begin
      cyc_hi = limits.max_cycle;
      if (pos_hi > limits.max_position) begin
        pos_hi = limits.max_position;
      end
    end
    cycle    = cyc_hi;
    position = pos_hi;
    if (cyc_hi < limits.min_cycle) begin
      cycle = limits.min_cycle;
      if (pos_hi < limits.min_position) begin
        position = limits.min_position;
      end
    end
  end

endmodule

>>> rtl/core/fepc_chan.sv
// One PWM channel: stored cycle and position, and the compare value for a frame count.
// Depends on fepc_pkg for widths and compare levels.
module fepc_chan (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        wr_en,
  input  logic [fepc_pkg::BYTE_W-1:0] set_cycle,
  input  logic [fepc_pkg::BYTE_W-1:0] set_position,
  input  logic [fepc_pkg::BYTE_W-1:0] frame,
  output logic [fepc_pkg::BYTE_W-1:0] compare
);

  logic [fepc_pkg::BYTE_W-1:0] stored_cycle;
  logic [fepc_pkg::BYTE_W-1:0] stored_position;

  always_ff @(posedge clk) begin
    if (rst) begin
      stored_cycle    <= '0;
      stored_position <= '0;
    end else if (wr_en) begin
      stored_cycle    <= set_cycle;
      stored_position <= set_position;
    end
  end

  always_comb begin
    if (frame == stored_cycle) begin
      compare = stored_position;
    end else if (frame < stored_cycle) begin
      compare = fepc_pkg::CMP_FULL;
    end else begin
      compare = fepc_pkg::CMP_EMPTY;
    end
  end

endmodule

>>> rtl/core/frame_extended_pwm_compare_core.sv
// Top level of the frame-extended PWM compare core.
// Depends on fepc_pkg, the interfaces in fepc_if, fepc_clamp and fepc_chan.

// This core stretches an 8-bit PWM to 16-bit resolution by spreading each duty value over
// a frame of 8-bit periods. A set item clamps its duty value (high byte is the cycle index,
// low byte the position) against the limit registers and stores it for the addressed channel;
// it gives no result. A tick item advances the frame counter, which wraps to zero once it
// reaches frame_length, and gives one result with the new count and each channel's compare
// value: 255 before its stored cycle, its stored position in that cycle, and 0 after it.
// Every item passes through an input register and, for a tick, a result register, so one
// item is taken per clock unless a tick waits for a full result register. A tick's
// result is offered from the cycle after the tick leaves the input register.
// The input register keeps taking items while a result waits, until the result register is
// full and a tick would need it; set items drain past a stalled result. Configuration writes
// are taken in every cycle and should only be made while the core is idle. A channel beyond
// CHANNELS ignores its set items and its compare output reads zero.
module frame_extended_pwm_compare_core #(
  parameter int unsigned CHANNELS = 2
) (
  input  logic                 clk,
  input  logic                 rst,
  fepc_cmd_if.sink             cmd,
  fepc_result_if.source        result,
  fepc_cfg_if.sink             cfg
);

  localparam int unsigned MAX_CHANNELS = 2;

  // Configuration registers.
  fepc_pkg::fepc_limits_t      limits;
  logic [fepc_pkg::BYTE_W-1:0] frame_length;

  // Input register.
  logic                        in_valid;
  logic                        in_operation;
  logic                        in_channel;
  logic [fepc_pkg::DUTY_W-1:0] in_duty;

  // Frame state and the result register.
  logic [fepc_pkg::BYTE_W-1:0] frame_counter;
  logic [fepc_pkg::BYTE_W-1:0] frame_counter_next;
  logic                        out_valid;
  logic [fepc_pkg::BYTE_W-1:0] out_frame;
  logic [fepc_pkg::BYTE_W-1:0] out_compare_a;
  logic [fepc_pkg::BYTE_W-1:0] out_compare_b;

  logic                        is_tick;
  logic                        advance;
  logic                        tick_fire;
  logic [fepc_pkg::BYTE_W-1:0] set_cycle;
  logic [fepc_pkg::BYTE_W-1:0] set_position;
  logic [fepc_pkg::BYTE_W-1:0] compare [MAX_CHANNELS];

  // The configuration port never stalls.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      limits.max_cycle    <= fepc_pkg::MAX_CYCLE_RST;
      limits.max_position <= fepc_pkg::MAX_POSITION_RST;
      limits.min_cycle    <= fepc_pkg::MIN_CYCLE_RST;
      limits.min_position <= fepc_pkg::MIN_POSITION_RST;
      frame_length        <= fepc_pkg::FRAME_LENGTH_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        fepc_pkg::REG_MAX_CYCLE:    limits.max_cycle    <= cfg.data;
        fepc_pkg::REG_MAX_POSITION: limits.max_position <= cfg.data;
        fepc_pkg::REG_MIN_CYCLE:    limits.min_cycle    <= cfg.data;
        fepc_pkg::REG_MIN_POSITION: limits.min_position <= cfg.data;
        fepc_pkg::REG_FRAME_LENGTH: frame_length        <= cfg.data;
        default: begin
          // Indexes past the register list are dropped.
        end
      endcase
    end
  end

  // A set item always leaves the input register; a tick needs room in the result register.
  assign is_tick   = (in_operation == fepc_pkg::OP_TICK);
  assign advance   = in_valid && (!is_tick || !out_valid || result.ready);
  assign tick_fire = advance && is_tick;
  assign cmd.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (cmd.ready) begin
      in_valid <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      in_operation <= cmd.operation;
      in_channel   <= cmd.channel;
      in_duty      <= cmd.duty_value;
    end
  end

  fepc_clamp u_clamp (
    .duty_value (in_duty),
    .limits     (limits),
    .cycle      (set_cycle),
    .position   (set_position)
  );

  // The counter steps by one and returns to zero once it reaches the frame length.
  always_comb begin
    frame_counter_next = frame_counter + 8'd1;
    if (frame_counter_next >= frame_length) begin
      frame_counter_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_counter <= '0;
    end else if (tick_fire) begin
      frame_counter <= frame_counter_next;
    end
  end

  // Channels that exist hold their settings; the others read as zero.
  for (genvar g = 0; g < MAX_CHANNELS; g++) begin : g_chan
    if (g < CHANNELS) begin : g_used
      logic wr_en;
      assign wr_en = advance && !is_tick && (in_channel == 1'(g));
      fepc_chan u_chan (
        .clk          (clk),
        .rst          (rst),
        .wr_en        (wr_en),
        .set_cycle    (set_cycle),
        .set_position (set_position),
        .frame        (frame_counter_next),
        .compare      (compare[g])
      );
    end else begin : g_unused
      assign compare[g] = fepc_pkg::CMP_EMPTY;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (tick_fire) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_fire) begin
      out_frame     <= frame_counter_next;
      out_compare_a <= compare[0];
      out_compare_b <= compare[1];
    end
  end

  assign result.valid       = out_valid;
  assign result.frame_index = out_frame;
  assign result.compare_a   = out_compare_a;
  assign result.compare_b   = out_compare_b;

endmodule
